@@ rtl/window_stats_range_tracker_macros.svh @@
// Assertion macros shared by the window stats RTL.
// No dependencies.
`ifndef WINDOW_STATS_RANGE_TRACKER_MACROS_SVH
`define WINDOW_STATS_RANGE_TRACKER_MACROS_SVH
// Implication check sampled on clk, quiet during reset.
`define WSRT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication check.
`define WSRT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ rtl/wsrt_pkg.sv @@
// Shared constants and types for window_stats_range_tracker.
// No dependencies.
package wsrt_pkg;
  localparam int WINDOW_DEF      = 50;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int MEAN_W = 24;
  localparam int STD_W  = 24;
  localparam int AXIS_W = 27;
  // accumulator widths sized for the largest allowed window and sample;
  // the sum of squares wraps at 64 bits
  localparam int SUM_W  = 41;
  localparam int SQ_W   = 64;
  localparam int ROOT_W = 32;
endpackage

@@ rtl/wsrt_front.sv @@
// Front end: takes samples and queues them for the compute engine.
// Depends on wsrt_pkg.
module wsrt_front #(
  parameter int SAMPLE_BITS = wsrt_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                          q_valid,
  input  logic                          q_ready,
  output logic signed [SAMPLE_BITS-1:0] q_sample
);
  import wsrt_pkg::*;
  `include "window_stats_range_tracker_macros.svh"

  // two-entry queue
  logic signed [SAMPLE_BITS-1:0] buf_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, wr_r;
  logic       push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_sample = buf_r[rd_r];
  assign push = in_valid && in_ready;
  assign pop  = q_valid && q_ready;

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_r <= ~wr_r;
      if (pop)  rd_r <= ~rd_r;
    end
    if (push) buf_r[wr_r] <= in_sample;
  end

  `WSRT_ASSERT_IMP(a_cnt_range, 1'b1, cnt_r <= 2'd2)
  `WSRT_ASSERT_NXT(a_full_push, cnt_r == 2'd2 && !pop, cnt_r == 2'd2)
  `WSRT_ASSERT_IMP(a_ptr_cnt, cnt_r == 2'd0 || cnt_r == 2'd2, rd_r == wr_r)
endmodule

@@ rtl/wsrt_back.sv @@
// Back end: ring memory, two passes over the window, reciprocal mean and root search.
// Depends on wsrt_pkg.
module wsrt_back #(
  parameter int WINDOW      = wsrt_pkg::WINDOW_DEF,
  parameter int SAMPLE_BITS = wsrt_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  logic signed [SAMPLE_BITS-1:0] q_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [wsrt_pkg::MEAN_W-1:0] out_window_mean,
  output logic [wsrt_pkg::STD_W-1:0]         out_std_dev,
  output logic signed [wsrt_pkg::AXIS_W-1:0] out_axis_high,
  output logic signed [wsrt_pkg::AXIS_W-1:0] out_axis_low
);
  import wsrt_pkg::*;
  `include "window_stats_range_tracker_macros.svh"

  localparam int AW = $clog2(WINDOW);
  localparam int CW = $clog2(WINDOW + 1);
  localparam logic [AW-1:0] LAST = AW'(WINDOW - 1);
  localparam logic [CW-1:0] WFULL = CW'(WINDOW);
  // mean: |sum| < 2^MAG_W, multiplied by ceil(2^SH / WINDOW), 8-bit digits MSB first
  localparam int MAG_W = SUM_W - 1;
  localparam int ND    = (MAG_W + 7) / 8;
  localparam int XW    = ND * 8;
  localparam int PW    = 2 * MAG_W + 1;
  localparam int SH    = MAG_W + AW;
  localparam logic [SUM_W-1:0] MREC =
    SUM_W'(((64'd1 << SH) + 64'(WINDOW - 1)) / 64'(WINDOW));
  // root search works on (WINDOW+1)-scaled squares
  localparam int RW = SQ_W + 9;
  localparam logic [RW-1:0] QD0 = RW'(WINDOW + 1) << (2 * (ROOT_W - 1));

  localparam logic [3:0] S_IDLE = 4'd0, S_P1 = 4'd1, S_MDIV = 4'd2, S_P2 = 4'd3,
                         S_ROOT = 4'd4, S_OUT = 4'd5;

  logic [3:0] st_r;
  logic signed [SAMPLE_BITS-1:0] ring [WINDOW];
  logic signed [SAMPLE_BITS-1:0] rd_q;
  logic [AW-1:0] wslot_r, ptr_r;
  logic [CW-1:0] held_r, idx_r;
  logic          rd_v_r;
  logic signed [SUM_W-1:0] sum_r, mean_r;
  logic signed [SAMPLE_BITS-1:0] min_r, max_r;
  logic [XW-1:0] xs_r;
  logic [PW-1:0] acc_r;
  logic [SQ_W-1:0] sq_r;
  logic [RW-1:0] t_r, p_r, qd_r;
  logic [ROOT_W-1:0] root_r, rb_r;
  logic [6:0] step_r;
  logic        neg_r;
  logic signed [SUM_W-1:0] sum_fin, dev;
  logic [SUM_W-1:0] dabs, quo;
  logic [SQ_W-1:0] sqr_d;
  logic [RW-1:0] rtry;
  logic signed [SUM_W-1:0] delta, spread;

  assign q_ready = (st_r == S_IDLE);
  assign sum_fin = sum_r + (rd_v_r ? SUM_W'(rd_q) : '0);
  assign quo  = SUM_W'(acc_r >> SH);
  assign dev  = SUM_W'(rd_q) - mean_r;
  assign dabs = dev[SUM_W-1] ? SUM_W'(-dev) : SUM_W'(dev);
  assign sqr_d = SQ_W'(dabs[31:0] * dabs[31:0]);
  assign rtry = t_r + p_r + qd_r;
  assign delta  = SUM_W'(max_r) - SUM_W'(min_r);
  assign spread = (delta * SUM_W'(7)) >>> 1;

  always_ff @(posedge clk) begin
    if (st_r == S_IDLE && q_valid) ring[wslot_r] <= q_sample;
    rd_q <= ring[ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; wslot_r <= '0; held_r <= '0; out_valid <= 1'b0; rd_v_r <= 1'b0;
    end else begin
      case (st_r)
        S_IDLE: if (q_valid) begin
          wslot_r <= (wslot_r == LAST) ? '0 : wslot_r + AW'(1);
          if (held_r != WFULL) held_r <= held_r + CW'(1);
          ptr_r <= wslot_r; idx_r <= '0; rd_v_r <= 1'b0;
          sum_r <= '0; min_r <= q_sample; max_r <= q_sample;
          st_r <= S_P1;
        end
        S_P1: begin
          if (rd_v_r) begin
            sum_r <= sum_r + SUM_W'(rd_q);
            if (rd_q < min_r) min_r <= rd_q;
            if (rd_q > max_r) max_r <= rd_q;
          end
          if (idx_r != held_r) begin
            ptr_r <= (ptr_r == '0) ? LAST : ptr_r - AW'(1);
            idx_r <= idx_r + CW'(1); rd_v_r <= 1'b1;
          end else begin
            rd_v_r <= 1'b0;
            st_r <= S_MDIV; step_r <= '0; acc_r <= '0;
            neg_r <= sum_fin[SUM_W-1];
            xs_r <= XW'(sum_fin[SUM_W-1] ? -sum_fin : sum_fin);
          end
        end
        S_MDIV: begin
          // |sum| * MREC, one digit a cycle; quotient is the top bits
          if (step_r == 7'(ND)) begin
            mean_r <= neg_r ? -quo : quo;
            st_r <= S_P2; ptr_r <= (wslot_r == '0) ? LAST : wslot_r - AW'(1);
            idx_r <= '0; rd_v_r <= 1'b0; sq_r <= '0;
          end else begin
            acc_r <= (acc_r << 8) + PW'(xs_r[XW-1 -: 8] * MREC);
            xs_r <= xs_r << 8;
            step_r <= step_r + 7'd1;
          end
        end
        S_P2: begin
          if (rd_v_r) sq_r <= sq_r + sqr_d;
          if (idx_r != held_r) begin
            ptr_r <= (ptr_r == '0) ? LAST : ptr_r - AW'(1);
            idx_r <= idx_r + CW'(1); rd_v_r <= 1'b1;
          end else begin
            rd_v_r <= 1'b0;
            st_r <= S_ROOT; sq_r <= sq_r + (rd_v_r ? sqr_d : '0);
            t_r <= '0; p_r <= '0; qd_r <= QD0; root_r <= '0;
            rb_r <= ROOT_W'(1) << (ROOT_W - 1);
          end
        end
        S_ROOT: begin
          // largest root with (WINDOW+1)*root^2 <= sq, one bit a cycle:
          // t = (W+1)*root^2, p = (W+1)*root*2*bit, qd = (W+1)*bit^2
          if (rtry <= RW'(sq_r)) begin
            t_r <= rtry;
            root_r <= root_r | rb_r;
            p_r <= (p_r + (qd_r << 1)) >> 1;
          end else begin
            p_r <= p_r >> 1;
          end
          qd_r <= qd_r >> 2;
          rb_r <= rb_r >> 1;
          if (rb_r[0]) st_r <= S_OUT;
        end
        S_OUT: if (!out_valid || out_ready) begin
          out_valid <= 1'b1;
          out_window_mean <= MEAN_W'(mean_r);
          out_std_dev <= STD_W'(root_r);
          out_axis_high <= AXIS_W'(SUM_W'(max_r) + spread);
          out_axis_low  <= AXIS_W'(SUM_W'(min_r) - spread);
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
      if (out_valid && out_ready && st_r != S_OUT) out_valid <= 1'b0;
    end
  end

  `WSRT_ASSERT_IMP(a_held_max, 1'b1, held_r <= WFULL)
  `WSRT_ASSERT_IMP(a_slot_max, 1'b1, wslot_r <= LAST)
  `WSRT_ASSERT_NXT(a_hold_out, out_valid && !out_ready, out_valid)
endmodule

@@ rtl/window_stats_range_tracker.sv @@
// Top level of the moving-window statistics tracker.
// Depends on wsrt_pkg, wsrt_front, wsrt_back.
//  channel  | ports                                   | dir
//  input    | in_valid in_ready in_sample             | in
//  result   | out_valid out_ready out_window_mean ... | out
// Each sample runs two passes over the ring memory, a reciprocal multiply for the
// mean and a bit-serial root search that folds in the divide by WINDOW+1; the
// engine takes no new sample until its result is loaded.
// A two-entry queue takes samples while the engine works.
// Reset is synchronous, active low; the ring has no reset. A held result stalls
// the engine only at its final load.
module window_stats_range_tracker #(
  parameter int WINDOW      = wsrt_pkg::WINDOW_DEF,
  parameter int SAMPLE_BITS = wsrt_pkg::SAMPLE_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [wsrt_pkg::MEAN_W-1:0] out_window_mean,
  output logic [wsrt_pkg::STD_W-1:0]         out_std_dev,
  output logic signed [wsrt_pkg::AXIS_W-1:0] out_axis_high,
  output logic signed [wsrt_pkg::AXIS_W-1:0] out_axis_low
);
  import wsrt_pkg::*;
  logic q_valid, q_ready;
  logic signed [SAMPLE_BITS-1:0] q_sample;

  wsrt_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_sample,
    .q_valid, .q_ready, .q_sample);

  wsrt_back #(.WINDOW(WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_sample,
    .out_valid, .out_ready, .out_window_mean, .out_std_dev,
    .out_axis_high, .out_axis_low);
endmodule
